// ----- hdl/pfde_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pfde_pkg;

  localparam logic [2:0] FN_CLEAR  = 3'd0;
  localparam logic [2:0] FN_PIXEL  = 3'd1;
  localparam logic [2:0] FN_RECT   = 3'd2;
  localparam logic [2:0] FN_BSTART = 3'd3;
  localparam logic [2:0] FN_BBYTE  = 3'd4;
  localparam logic [2:0] FN_READ   = 3'd5;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_PIXEL = 2'd1,
    OP_READ  = 2'd2,
    OP_ZERO  = 2'd3
  } pfde_op_t;

  typedef struct packed {
    pfde_op_t   op;
    logic [2:0] bit_sel;
    logic       color;
  } pfde_req_t;

endpackage

`default_nettype wire

// ----- hdl/pfde_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pfde_store
  import pfde_pkg::*;
#(
  parameter int ADDR_W = 10
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pfde_req_t         req,
  input  wire logic [ADDR_W-1:0] req_addr,
  output logic      [7:0]        rd_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [7:0]        mem [DEPTH];
  logic [7:0]        mem_q_r;

  pfde_op_t          op_b_r;
  logic [ADDR_W-1:0] addr_b_r;
  logic [2:0]        bit_b_r;
  logic              color_b_r;

  logic              fwd_en_r;
  logic [ADDR_W-1:0] fwd_addr_r;
  logic [7:0]        fwd_data_r;

  logic              wr_en;
  logic [7:0]        wr_data;
  logic [7:0]        src;
  logic [7:0]        mask;

  // write of the previous cycle is not yet visible in the registered read
  assign src  = (fwd_en_r && (fwd_addr_r == addr_b_r)) ? fwd_data_r : mem_q_r;
  assign mask = 8'b0000_0001 << bit_b_r;

  always_comb begin
    wr_en   = 1'b0;
    wr_data = src;
    unique case (op_b_r)
      OP_PIXEL: begin
        wr_en   = 1'b1;
        wr_data = color_b_r ? (src | mask) : (src & ~mask);
      end
      OP_ZERO: begin
        wr_en   = 1'b1;
        wr_data = 8'h00;
      end
      OP_NONE, OP_READ: begin
        wr_en   = 1'b0;
      end
      default: begin
        wr_en   = 1'b0;
      end
    endcase
  end

  assign rd_data = src;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr_b_r] <= wr_data;
    end
    mem_q_r <= mem[req_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_b_r   <= OP_NONE;
      fwd_en_r <= 1'b0;
    end else begin
      op_b_r   <= req.op;
      fwd_en_r <= wr_en;
    end
    addr_b_r   <= req_addr;
    bit_b_r    <= req.bit_sel;
    color_b_r  <= req.color;
    fwd_addr_r <= addr_b_r;
    fwd_data_r <= wr_data;
  end

endmodule

`default_nettype wire

// ----- hdl/pfde_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pfde_engine
  import pfde_pkg::*;
#(
  parameter int PIXEL_COLUMNS = 128,
  parameter int PIXEL_ROWS    = 64,
  localparam int COL_W  = (PIXEL_COLUMNS > 1) ? $clog2(PIXEL_COLUMNS) : 1,
  localparam int PAGES  = (PIXEL_ROWS + 7) / 8,
  localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1,
  localparam int ADDR_W = COL_W + PAGE_W
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        in_func,
  input  wire logic signed [8:0] in_x_pos,
  input  wire logic signed [8:0] in_y_pos,
  input  wire logic [7:0]        in_width_px,
  input  wire logic [7:0]        in_height_px,
  input  wire logic              in_color,
  input  wire logic [7:0]        in_data_byte,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output logic [7:0]             res_read_data,
  output logic                   res_overflow,
  output pfde_req_t              req,
  output logic [ADDR_W-1:0]      req_addr,
  input  wire logic [7:0]        rd_data
);

  localparam logic [9:0] COL_LIM = 10'(PIXEL_COLUMNS);
  localparam logic [9:0] ROW_LIM = 10'(PIXEL_ROWS);

  typedef enum logic [8:0] {
    ST_INIT   = 9'b0_0000_0001,
    ST_IDLE   = 9'b0_0000_0010,
    ST_CLEAR  = 9'b0_0000_0100,
    ST_PIXEL  = 9'b0_0000_1000,
    ST_RECT   = 9'b0_0001_0000,
    ST_BLIT   = 9'b0_0010_0000,
    ST_RDISS  = 9'b0_0100_0000,
    ST_RDWAIT = 9'b0_1000_0000,
    ST_RES    = 9'b1_0000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic signed [8:0] x_r, x_nxt;
  logic signed [8:0] y_r, y_nxt;
  logic [7:0]        w_r, w_nxt;
  logic [7:0]        h_r, h_nxt;
  logic              color_r, color_nxt;
  logic [7:0]        data_r, data_nxt;
  logic [7:0]        dx_r, dx_nxt;
  logic [7:0]        dy_r, dy_nxt;
  logic [2:0]        bit_r, bit_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic signed [8:0] bl_ox_r, bl_ox_nxt;
  logic signed [8:0] bl_oy_r, bl_oy_nxt;
  logic [7:0]        bl_w_r, bl_w_nxt;
  logic [7:0]        bl_h_r, bl_h_nxt;
  logic [7:0]        bl_col_r, bl_col_nxt;
  logic [8:0]        bl_row_r, bl_row_nxt;
  logic [7:0]        res_rd_r, res_rd_nxt;
  logic              res_ovf_r, res_ovf_nxt;

  logic signed [10:0] cx;
  logic signed [10:0] cy;
  logic               pix_color;
  logic               in_range;
  logic [ADDR_W-1:0]  px_addr;

  always_comb begin
    priority if (state_r == ST_RECT) begin
      cx        = {{2{x_r[8]}}, x_r} + {3'b000, dx_r};
      cy        = {{2{y_r[8]}}, y_r} + {3'b000, dy_r};
      pix_color = color_r;
    end else if (state_r == ST_BLIT) begin
      cx        = {{2{bl_ox_r[8]}}, bl_ox_r} + {3'b000, bl_col_r};
      cy        = {{2{bl_oy_r[8]}}, bl_oy_r} + {2'b00, bl_row_r};
      pix_color = data_r[bit_r];
    end else begin
      cx        = {{2{x_r[8]}}, x_r};
      cy        = {{2{y_r[8]}}, y_r};
      pix_color = color_r;
    end
  end

  assign in_range = !cx[10] && (cx[9:0] < COL_LIM) && !cy[10] && (cy[9:0] < ROW_LIM);
  assign px_addr  = {cy[3 +: PAGE_W], cx[COL_W-1:0]};

  assign in_ready      = (state_r == ST_IDLE);
  assign res_valid     = (state_r == ST_RES);
  assign res_read_data = res_rd_r;
  assign res_overflow  = res_ovf_r;

  always_comb begin
    state_nxt    = state_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    w_nxt        = w_r;
    h_nxt        = h_r;
    color_nxt    = color_r;
    data_nxt     = data_r;
    dx_nxt       = dx_r;
    dy_nxt       = dy_r;
    bit_nxt      = bit_r;
    clr_addr_nxt = clr_addr_r;
    bl_ox_nxt    = bl_ox_r;
    bl_oy_nxt    = bl_oy_r;
    bl_w_nxt     = bl_w_r;
    bl_h_nxt     = bl_h_r;
    bl_col_nxt   = bl_col_r;
    bl_row_nxt   = bl_row_r;
    res_rd_nxt   = res_rd_r;
    res_ovf_nxt  = res_ovf_r;
    req.op       = OP_NONE;
    req.bit_sel  = cy[2:0];
    req.color    = pix_color;
    req_addr     = px_addr;

    unique case (state_r)
      ST_INIT, ST_CLEAR: begin
        req.op       = OP_ZERO;
        req_addr     = clr_addr_r;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (&clr_addr_r) begin
          state_nxt = (state_r == ST_INIT) ? ST_IDLE : ST_RES;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          x_nxt        = in_x_pos;
          y_nxt        = in_y_pos;
          w_nxt        = in_width_px;
          h_nxt        = in_height_px;
          color_nxt    = in_color;
          data_nxt     = in_data_byte;
          dx_nxt       = 8'd0;
          dy_nxt       = 8'd0;
          bit_nxt      = 3'd7;
          clr_addr_nxt = '0;
          res_rd_nxt   = 8'd0;
          res_ovf_nxt  = 1'b0;
          unique case (in_func)
            FN_CLEAR:  state_nxt = ST_CLEAR;
            FN_PIXEL:  state_nxt = ST_PIXEL;
            FN_RECT: begin
              state_nxt = ((in_width_px == 8'd0) || (in_height_px == 8'd0)) ? ST_RES : ST_RECT;
            end
            FN_BSTART: begin
              bl_ox_nxt  = in_x_pos;
              bl_oy_nxt  = in_y_pos;
              bl_w_nxt   = in_width_px;
              bl_h_nxt   = in_height_px;
              bl_col_nxt = 8'd0;
              bl_row_nxt = 9'd0;
              state_nxt  = ST_RES;
            end
            FN_BBYTE:  state_nxt = ST_BLIT;
            FN_READ:   state_nxt = ST_RDISS;
            default:   state_nxt = ST_RES;
          endcase
        end
      end
      ST_PIXEL: begin
        if (in_range) begin
          req.op = OP_PIXEL;
        end
        state_nxt = ST_RES;
      end
      ST_RECT: begin
        if (in_range) begin
          req.op = OP_PIXEL;
        end
        if (dy_r == h_r - 8'd1) begin
          dy_nxt = 8'd0;
          if (dx_r == w_r - 8'd1) begin
            state_nxt = ST_RES;
          end else begin
            dx_nxt = dx_r + 8'd1;
          end
        end else begin
          dy_nxt = dy_r + 8'd1;
        end
      end
      ST_BLIT: begin
        if ((bl_w_r == 8'd0) || (bl_row_r >= {1'b0, bl_h_r})) begin
          res_ovf_nxt = 1'b1;
        end else begin
          if (in_range) begin
            req.op = OP_PIXEL;
          end
          if (bl_col_r == bl_w_r - 8'd1) begin
            bl_col_nxt = 8'd0;
            bl_row_nxt = bl_row_r + 9'd1;
          end else begin
            bl_col_nxt = bl_col_r + 8'd1;
          end
        end
        bit_nxt = bit_r - 3'd1;
        if (bit_r == 3'd0) begin
          state_nxt = ST_RES;
        end
      end
      ST_RDISS: begin
        if (in_range) begin
          req.op = OP_READ;
        end
        state_nxt = ST_RDWAIT;
      end
      ST_RDWAIT: begin
        if (in_range) begin
          res_rd_nxt = rd_data;
        end
        state_nxt = ST_RES;
      end
      ST_RES: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_INIT;
      clr_addr_r <= '0;
      bl_ox_r    <= 9'sd0;
      bl_oy_r    <= 9'sd0;
      bl_w_r     <= 8'd0;
      bl_h_r     <= 8'd0;
      bl_col_r   <= 8'd0;
      bl_row_r   <= 9'd0;
      res_rd_r   <= 8'd0;
      res_ovf_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      bl_ox_r    <= bl_ox_nxt;
      bl_oy_r    <= bl_oy_nxt;
      bl_w_r     <= bl_w_nxt;
      bl_h_r     <= bl_h_nxt;
      bl_col_r   <= bl_col_nxt;
      bl_row_r   <= bl_row_nxt;
      res_rd_r   <= res_rd_nxt;
      res_ovf_r  <= res_ovf_nxt;
    end
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    w_r     <= w_nxt;
    h_r     <= h_nxt;
    color_r <= color_nxt;
    data_r  <= data_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    bit_r   <= bit_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/page_framebuffer_draw_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Monochrome PIXEL_COLUMNS x PIXEL_ROWS framebuffer held as pages of column
// bytes (pixel x,y is bit y%8 of the byte at page y/8, column x) in one
// synchronous memory with a read-modify-write pipe that touches one pixel per
// cycle. Every input transfer yields exactly one output transfer. Clear zeroes
// every byte of the store, which holds the column count and the page count,
// each rounded up to a power of two, multiplied (1024 at 128x64). After reset
// the same clearing pass runs first, and in_tready stays low until it ends. A
// new item is taken while the previous result still sits in the output
// register.
module page_framebuffer_draw_engine
  import pfde_pkg::*;
#(
  parameter int PIXEL_COLUMNS = 128,
  parameter int PIXEL_ROWS    = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // x_pos[8:0], y_pos[17:9], width_px[25:18], height_px[33:26], color[34],
  // data_byte[42:35], zero [47:43]
  input  wire logic [47:0] in_tdata,
  // func[2:0]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // read_data[7:0], bitmap_overflow[8], zero [15:9]
  output logic [15:0]      out_tdata
);

  localparam int COL_W  = (PIXEL_COLUMNS > 1) ? $clog2(PIXEL_COLUMNS) : 1;
  localparam int PAGES  = (PIXEL_ROWS + 7) / 8;
  localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int ADDR_W = COL_W + PAGE_W;

  logic              res_valid;
  logic              res_ready;
  logic [7:0]        res_read_data;
  logic              res_overflow;
  pfde_req_t         req;
  logic [ADDR_W-1:0] req_addr;
  logic [7:0]        rd_data;

  logic              out_valid_r, out_valid_nxt;
  logic [15:0]       out_data_r, out_data_nxt;

  pfde_engine #(
    .PIXEL_COLUMNS(PIXEL_COLUMNS),
    .PIXEL_ROWS   (PIXEL_ROWS)
  ) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_func      (in_tuser),
    .in_x_pos     (in_tdata[8:0]),
    .in_y_pos     (in_tdata[17:9]),
    .in_width_px  (in_tdata[25:18]),
    .in_height_px (in_tdata[33:26]),
    .in_color     (in_tdata[34]),
    .in_data_byte (in_tdata[42:35]),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res_read_data(res_read_data),
    .res_overflow (res_overflow),
    .req          (req),
    .req_addr     (req_addr),
    .rd_data      (rd_data)
  );

  pfde_store #(
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .req_addr(req_addr),
    .rd_data (rd_data)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {7'd0, res_overflow, res_read_data};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on two consecutive cycles");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |=> out_tvalid)
    else $error("finished result not loaded into output register");

  a_ovf_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[8] && (out_tdata[7:0] != 8'd0)))
    else $error("overflow flagged together with read data");
`endif

endmodule

`default_nettype wire

// ----- dv/page_framebuffer_draw_engine_tb.sv -----
`timescale 1ns / 1ps

module page_framebuffer_draw_engine_tb;
  import pfde_pkg::*;

  localparam int FB_COLS = 128;
  localparam int FB_ROWS = 64;
  localparam int FB_BYTES = FB_COLS * ((FB_ROWS + 7) / 8);
  localparam logic [2:0] FN_SPARE_A = 3'd6;
  localparam logic [2:0] FN_SPARE_B = 3'd7;
  localparam int RANDOM_ITEMS = 1050;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES = 500;

  class frame_tracker;
    logic [7:0] pixels [FB_BYTES];
    logic signed [8:0] org_x, org_y;
    logic [7:0] blit_w, blit_h, blit_col;
    logic [8:0] blit_row;
    logic [15:0] pending [$];
    int errors;
    int checked;

    function new();
      wipe();
      org_x = '0;
      org_y = '0;
      blit_w = '0;
      blit_h = '0;
      blit_col = '0;
      blit_row = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void wipe();
      foreach (pixels[i]) pixels[i] = 8'h00;
    endfunction

    function void plot(int x, int y, logic on);
      if (x < 0 || x >= FB_COLS || y < 0 || y >= FB_ROWS) return;
      pixels[x + (y / 8) * FB_COLS][y % 8] = on;
    endfunction

    // apply one accepted transfer to the image and queue its result
    function void note_item(logic [2:0] fn, logic [47:0] d);
      int x, y;
      logic [7:0] w, h, bits, rd;
      logic col, ovf;
      x = int'($signed(d[8:0]));
      y = int'($signed(d[17:9]));
      w = d[25:18];
      h = d[33:26];
      col = d[34];
      bits = d[42:35];
      rd = 8'h00;
      ovf = 1'b0;
      case (fn)
        FN_CLEAR: wipe();
        FN_PIXEL: plot(x, y, col);
        FN_RECT: begin
          for (int dx = 0; dx < w; dx++)
            for (int dy = 0; dy < h; dy++)
              plot(x + dx, y + dy, col);
        end
        FN_BSTART: begin
          org_x = d[8:0];
          org_y = d[17:9];
          blit_w = w;
          blit_h = h;
          blit_col = '0;
          blit_row = '0;
        end
        FN_BBYTE: begin
          for (int b = 7; b >= 0; b--) begin
            if (blit_w == 0 || blit_row >= blit_h) begin
              ovf = 1'b1;
            end else begin
              plot(int'(org_x) + int'(blit_col), int'(org_y) + int'(blit_row), bits[b]);
              blit_col++;
              if (blit_col >= blit_w) begin
                blit_col = '0;
                blit_row++;
              end
            end
          end
        end
        FN_READ: begin
          if (x >= 0 && x < FB_COLS && y >= 0 && y < FB_ROWS)
            rd = pixels[x + (y / 8) * FB_COLS];
        end
        default: ;
      endcase
      pending.push_back({7'b0, ovf, rd});
    endfunction

    function void check_result(logic [15:0] got);
      logic [15:0] want;
      if (pending.size() == 0) begin
        if (errors < 40)
          $display("%0t: unexpected result, expected none, actual 0x%04h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got[7:0] !== want[7:0]) begin
        if (errors < 40)
          $display("%0t: read_data expected 0x%02h actual 0x%02h", $time, want[7:0], got[7:0]);
        errors++;
      end
      if (got[8] !== want[8]) begin
        if (errors < 40)
          $display("%0t: bitmap_overflow expected %0b actual %0b", $time, want[8], got[8]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [47:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;

  frame_tracker sb;
  int items_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int rx_cyc = 0;
  int rx_mode = 0;
  int hold_left = 0;
  int holds_done = 0;

  always #5 clk = ~clk;

  page_framebuffer_draw_engine uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  task automatic send_item(input logic [2:0] fn, input logic [8:0] x, input logic [8:0] y,
                           input logic [7:0] w, input logic [7:0] h, input logic col,
                           input logic [7:0] bits);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 30) : $urandom_range(1, 4))
          @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tuser <= fn;
    in_tdata <= {5'b0, bits, col, h, w, y, x};
    do @(posedge clk); while (!in_tready);
    sb.note_item(fn, {5'b0, bits, col, h, w, y, x});
    items_sent++;
    burst_left--;
  endtask

  task automatic do_read(input logic [8:0] x, input logic [8:0] y);
    send_item(FN_READ, x, y, 8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
  endtask

  task automatic do_pixel(input logic [8:0] x, input logic [8:0] y, input logic col);
    send_item(FN_PIXEL, x, y, 8'($urandom), 8'($urandom), col, 8'($urandom));
  endtask

  task automatic do_rect(input logic [8:0] x, input logic [8:0] y, input logic [7:0] w,
                         input logic [7:0] h, input logic col);
    send_item(FN_RECT, x, y, w, h, col, 8'($urandom));
  endtask

  task automatic do_start(input logic [8:0] x, input logic [8:0] y, input logic [7:0] w,
                          input logic [7:0] h);
    send_item(FN_BSTART, x, y, w, h, 1'($urandom), 8'($urandom));
  endtask

  task automatic do_byte(input logic [7:0] bits);
    send_item(FN_BBYTE, 9'($urandom), 9'($urandom), 8'($urandom), 8'($urandom),
              1'($urandom), bits);
  endtask

  task automatic do_any(input logic [2:0] fn);
    send_item(fn, 9'($urandom), 9'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
              8'($urandom));
  endtask

  // mostly on screen, sometimes just off the edge, sometimes anywhere
  function automatic logic [8:0] pick_coord(int span);
    int r, v;
    r = $urandom_range(0, 9);
    if (r < 8) v = $urandom_range(0, span - 1);
    else if (r == 8) v = int'($urandom_range(0, 20)) - 10 + ($urandom_range(0, 1) ? span : 0);
    else v = int'($urandom_range(0, 511)) - 256;
    return v[8:0];
  endfunction

  task automatic run_directed();
    do_read(9'd0, 9'd0);
    do_pixel(9'd0, 9'd0, 1'b1);
    do_pixel(9'd127, 9'd63, 1'b1);
    do_pixel(-9'sd1, 9'd5, 1'b1);
    do_pixel(9'd128, 9'd0, 1'b1);
    do_pixel(9'd0, 9'd64, 1'b1);
    do_pixel(9'h100, 9'h100, 1'b1);
    do_pixel(9'd255, 9'd255, 1'b1);
    do_read(9'd0, 9'd0);
    do_read(9'd127, 9'd56);
    do_read(-9'sd1, 9'd0);
    do_read(9'd0, 9'd64);
    do_pixel(9'd0, 9'd0, 1'b0);
    do_rect(-9'sd3, -9'sd3, 8'd10, 8'd12, 1'b1);
    do_read(9'd6, 9'd8);
    do_rect(9'd10, 9'd10, 8'd0, 8'd5, 1'b1);
    do_rect(9'd0, 9'd0, 8'd255, 8'd255, 1'b1);
    do_read(9'd100, 9'd40);
    do_start(9'd120, 9'd60, 8'd10, 8'd2);
    do_byte(8'h00);
    do_byte(8'hA5);
    do_byte(8'hFF);
    do_read(9'd120, 9'd56);
    do_start(9'd5, 9'd5, 8'd0, 8'd4);
    do_byte(8'h3C);
    send_item(FN_SPARE_A, 9'h1FF, 9'h1FF, 8'hFF, 8'hFF, 1'b1, 8'hFF);
    send_item(FN_SPARE_B, 9'h1FF, 9'h1FF, 8'hFF, 8'hFF, 1'b1, 8'hFF);
    do_any(FN_CLEAR);
    do_read(9'd127, 9'd56);
  endtask

  task automatic run_random();
    int sel, n, ox, oy;
    logic [7:0] w, h;
    logic [2:0] fn;
    while (items_sent < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 32) begin
        ox = int'($signed(pick_coord(FB_COLS)));
        oy = int'($signed(pick_coord(FB_ROWS)));
        w = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 24));
        h = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 12));
        do_start(9'(ox), 9'(oy), w, h);
        n = (int'(w) * int'(h) + 7) / 8 + int'($urandom_range(0, 2));
        if (n > 24) n = 24;
        if (n == 0) n = 1;
        repeat (n) do_byte(8'($urandom));
        repeat ($urandom_range(0, 4))
          do_read(9'(ox + int'($urandom_range(0, w))), 9'(oy + int'($urandom_range(0, h))));
      end else if (sel < 52) begin
        repeat ($urandom_range(3, 12)) do_read(pick_coord(FB_COLS), pick_coord(FB_ROWS));
      end else if (sel < 70) begin
        ox = int'($signed(pick_coord(FB_COLS)));
        oy = int'($signed(pick_coord(FB_ROWS)));
        repeat ($urandom_range(1, 6))
          do_pixel(9'(ox + int'($urandom_range(0, 7))), 9'(oy + int'($urandom_range(0, 7))),
                   1'($urandom));
        repeat ($urandom_range(1, 4))
          do_read(9'(ox + int'($urandom_range(0, 7))), 9'(oy + int'($urandom_range(0, 7))));
      end else if (sel < 84) begin
        ox = int'($signed(pick_coord(FB_COLS)));
        oy = int'($signed(pick_coord(FB_ROWS)));
        if ($urandom_range(0, 59) == 0)
          do_rect(9'(ox), 9'(oy), 8'($urandom_range(128, 255)), 8'($urandom_range(128, 255)),
                  1'($urandom));
        else
          do_rect(9'(ox), 9'(oy), 8'($urandom_range(0, 16)), 8'($urandom_range(0, 16)),
                  1'($urandom));
        repeat ($urandom_range(1, 4))
          do_read(9'(ox + int'($urandom_range(0, 17))), 9'(oy + int'($urandom_range(0, 17))));
      end else if (sel < 86) begin
        do_any(FN_CLEAR);
      end else begin
        fn = 3'($urandom_range(0, 7));
        if (fn == FN_RECT)
          send_item(fn, 9'($urandom), 9'($urandom), 8'($urandom_range(0, 15)),
                    8'($urandom_range(0, 15)), 1'($urandom), 8'($urandom));
        else
          do_any(fn);
      end
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // receiver: rotating stall patterns plus two long hold-offs
  always @(posedge clk) begin
    rx_cyc++;
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (holds_done < 2 && sb.checked >= 200 + holds_done * 500) begin
      hold_left = HOLD_CYCLES;
      holds_done++;
      out_tready <= 1'b0;
    end else begin
      if (rx_cyc % 64 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= (rx_cyc % 4 == 0);
        default: out_tready <= ($urandom_range(0, 6) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
